>>> hdl/rc4b64_pkg.sv
// ----------------------------------------------------------------------------
// rc4b64_pkg
// Shared types, key bytes and the base64 character map for the challenge
// encoder.
// ----------------------------------------------------------------------------
package rc4b64_pkg;

    localparam int KEY_LEN    = 6;
    localparam int KEY_SLOTS  = 16;
    localparam int KIDX_W     = $clog2(KEY_SLOTS);
    localparam int PERM_DEPTH = 256;
    localparam int PERM_AW    = $clog2(PERM_DEPTH);

    typedef logic [7:0]         byte_t;
    typedef logic [5:0]         sextet_t;
    typedef logic [PERM_AW-1:0] perm_addr_t;
    typedef logic [KIDX_W-1:0]  key_idx_t;

    localparam byte_t CHAR_UPPER_A = 8'h41;
    localparam byte_t CHAR_LOWER_A = 8'h61;
    localparam byte_t CHAR_ZERO    = 8'h30;
    localparam byte_t CHAR_PLUS    = 8'h2b;
    localparam byte_t CHAR_SLASH   = 8'h2f;

    // fixed key, positions past the key text read as zero
    function automatic byte_t key_byte(key_idx_t idx);
        byte_t kb;
        case (idx)
            4'd0:    kb = 8'h41;
            4'd1:    kb = 8'h76;
            4'd2:    kb = 8'h33;
            4'd3:    kb = 8'h4d;
            4'd4:    kb = 8'h39;
            4'd5:    kb = 8'h39;
            default: kb = 8'h00;
        endcase
        return kb;
    endfunction

    function automatic byte_t b64_char(sextet_t v);
        byte_t w;
        byte_t ch;
        w = {2'b00, v};
        if (v < 6'd26)
            ch = w + CHAR_UPPER_A;
        else if (v < 6'd52)
            ch = w - 8'd26 + CHAR_LOWER_A;
        else if (v < 6'd62)
            ch = w - 8'd52 + CHAR_ZERO;
        else if (v == 6'd62)
            ch = CHAR_PLUS;
        else
            ch = CHAR_SLASH;
        return ch;
    endfunction

endpackage

>>> hdl/rc4b64_if.sv
// ----------------------------------------------------------------------------
// rc4b64 channel interfaces
// Valid/ready channels for challenge bytes in and response characters out.
// ----------------------------------------------------------------------------
interface rc4b64_chal_if;
    import rc4b64_pkg::*;

    logic  valid;
    logic  ready;
    byte_t challenge_byte;
    logic  final_byte;

    modport source (output valid, output challenge_byte, output final_byte, input ready);
    modport sink   (input valid, input challenge_byte, input final_byte, output ready);
endinterface

interface rc4b64_resp_if;
    import rc4b64_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_char;
    logic  char_valid;
    logic  group_last;
    logic  response_end;

    modport source (output valid, output out_char, output char_valid, output group_last,
                    output response_end, input ready);
    modport sink   (input valid, input out_char, input char_valid, input group_last,
                    input response_end, output ready);
endinterface

>>> hdl/rc4_variant_challenge_base64_core.sv
// ----------------------------------------------------------------------------
// rc4_variant_challenge_base64_core
// Modified RC4 stream cipher over challenge bytes, packed into base64 text.
// ----------------------------------------------------------------------------
//  channel     | dir | payload                                         | role
//  ------------+-----+-------------------------------------------------+-----------------
//  challenge   | in  | challenge_byte, final_byte                      | plaintext bytes
//  response    | out | out_char, char_valid, group_last, response_end  | base64 characters
//
//  a byte passes through the permutation memory, which has one read and one write port
//  (three reads, two writes, each read registered), then its results go out as characters
//  the first byte of a challenge first loads identity, then runs the key schedule
//  (read i, read j, write j, write i per step), all through the same memory
//  after reset the first byte triggers the key schedule; no clearing pass
//  a stalled response holds its register; challenge is taken again once idle
// ----------------------------------------------------------------------------
module rc4_variant_challenge_base64_core
(
    input  logic          clk,
    input  logic          rst_n,
    rc4b64_chal_if.sink   challenge,
    rc4b64_resp_if.source response
);
    import rc4b64_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_FILL  = 13'b0000000000010,
        ST_K_RDI = 13'b0000000000100,
        ST_K_RDJ = 13'b0000000001000,
        ST_K_WRJ = 13'b0000000010000,
        ST_K_WRI = 13'b0000000100000,
        ST_B_RDA = 13'b0000001000000,
        ST_B_RDB = 13'b0000010000000,
        ST_B_WRB = 13'b0000100000000,
        ST_B_WRA = 13'b0001000000000,
        ST_B_RDK = 13'b0010000000000,
        ST_B_ENC = 13'b0100000000000,
        ST_EMIT  = 13'b1000000000000
    } state_t;

    localparam perm_addr_t LAST_ADDR = perm_addr_t'(PERM_DEPTH - 1);
    localparam key_idx_t   LAST_KIDX = key_idx_t'(KEY_LEN - 1);

    state_t     state_reg, state_next;
    perm_addr_t cnt_reg, cnt_next;
    perm_addr_t j_reg, j_next;
    key_idx_t   kidx_reg, kidx_next;
    perm_addr_t ia_reg, ia_next;
    perm_addr_t ib_reg, ib_next;
    byte_t      x_reg, x_next;
    byte_t      y_reg, y_next;
    byte_t      c_reg, c_next;
    logic       fin_reg, fin_next;
    byte_t      held0_reg, held0_next;
    byte_t      held1_reg, held1_next;
    byte_t      e_reg, e_next;
    logic [1:0] gpos_reg, gpos_next;
    logic       need_sched_reg, need_sched_next;
    logic [1:0] emit_k_reg, emit_k_next;
    logic       emit_mark_reg, emit_mark_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_char_reg, out_char_next;
    logic       out_cv_reg, out_cv_next;
    logic       out_gl_reg, out_gl_next;
    logic       out_re_reg, out_re_next;

    // permutation memory
    byte_t      perm_mem [PERM_DEPTH];
    byte_t      mem_rdata_reg;
    logic       mem_we;
    perm_addr_t mem_waddr;
    byte_t      mem_wdata;
    perm_addr_t mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= perm_mem[mem_raddr];
    end

    logic       out_free;
    perm_addr_t sum_addr;
    byte_t      enc;
    sextet_t    sextet;

    assign out_free = !out_valid_reg || response.ready;
    assign enc      = c_reg ^ mem_rdata_reg;

    always_comb
    begin
        case (emit_k_reg)
            2'd0:    sextet = held0_reg[7:2];
            2'd1:    sextet = {held0_reg[1:0], held1_reg[7:4]};
            2'd2:    sextet = {held1_reg[3:0], e_reg[7:6]};
            default: sextet = e_reg[5:0];
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        j_next          = j_reg;
        kidx_next       = kidx_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        c_next          = c_reg;
        fin_next        = fin_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        e_next          = e_reg;
        gpos_next       = gpos_reg;
        need_sched_next = need_sched_reg;
        emit_k_next     = emit_k_reg;
        emit_mark_next  = emit_mark_reg;
        out_valid_next  = out_valid_reg && !response.ready;
        out_char_next   = out_char_reg;
        out_cv_next     = out_cv_reg;
        out_gl_next     = out_gl_reg;
        out_re_next     = out_re_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg;
        mem_wdata       = cnt_reg;
        mem_raddr       = cnt_reg;
        sum_addr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (challenge.valid)
                begin
                    c_next   = challenge.challenge_byte;
                    fin_next = challenge.final_byte;
                    cnt_next = '0;
                    state_next = need_sched_reg ? ST_FILL : ST_B_RDA;
                end
            end
            ST_FILL:
            begin
                // load identity before the key schedule
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = ST_K_RDI;
                end
            end
            ST_K_RDI:
            begin
                state_next = ST_K_RDJ;
            end
            ST_K_RDJ:
            begin
                x_next     = mem_rdata_reg;
                sum_addr   = j_reg + mem_rdata_reg + key_byte(kidx_reg);
                j_next     = sum_addr;
                mem_raddr  = sum_addr;
                state_next = ST_K_WRJ;
            end
            ST_K_WRJ:
            begin
                y_next     = mem_rdata_reg;
                mem_we     = 1'b1;
                mem_waddr  = j_reg;
                mem_wdata  = x_reg;
                state_next = ST_K_WRI;
            end
            ST_K_WRI:
            begin
                mem_we    = 1'b1;
                mem_wdata = y_reg;
                kidx_next = (kidx_reg == LAST_KIDX) ? '0 : kidx_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    need_sched_next = 1'b0;
                    ia_next         = '0;
                    ib_next         = '0;
                    gpos_next       = '0;
                    state_next      = ST_B_RDA;
                end
                else
                begin
                    state_next = ST_K_RDI;
                end
            end
            ST_B_RDA:
            begin
                sum_addr   = ia_reg + c_reg + 1'b1;
                ia_next    = sum_addr;
                mem_raddr  = sum_addr;
                state_next = ST_B_RDB;
            end
            ST_B_RDB:
            begin
                x_next     = mem_rdata_reg;
                sum_addr   = ib_reg + mem_rdata_reg;
                ib_next    = sum_addr;
                mem_raddr  = sum_addr;
                state_next = ST_B_WRB;
            end
            ST_B_WRB:
            begin
                y_next     = mem_rdata_reg;
                mem_we     = 1'b1;
                mem_waddr  = ib_reg;
                mem_wdata  = x_reg;
                state_next = ST_B_WRA;
            end
            ST_B_WRA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ia_reg;
                mem_wdata  = y_reg;
                state_next = ST_B_RDK;
            end
            ST_B_RDK:
            begin
                mem_raddr  = x_reg + y_reg;
                state_next = ST_B_ENC;
            end
            ST_B_ENC:
            begin
                emit_k_next    = '0;
                emit_mark_next = 1'b0;
                state_next     = ST_IDLE;
                if (gpos_reg < 2'd2)
                begin
                    if (gpos_reg[0])
                        held1_next = enc;
                    else
                        held0_next = enc;
                    gpos_next = gpos_reg + 1'b1;
                    if (fin_reg)
                    begin
                        // partial group dropped, end marker only
                        emit_mark_next = 1'b1;
                        state_next     = ST_EMIT;
                    end
                end
                else
                begin
                    e_next     = enc;
                    gpos_next  = '0;
                    state_next = ST_EMIT;
                end
                if (fin_reg)
                begin
                    need_sched_next = 1'b1;
                    gpos_next       = '0;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (emit_mark_reg)
                    begin
                        out_char_next = '0;
                        out_cv_next   = 1'b0;
                        out_gl_next   = 1'b1;
                        out_re_next   = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_char_next = b64_char(sextet);
                        out_cv_next   = 1'b1;
                        out_gl_next   = (emit_k_reg == 2'd3);
                        out_re_next   = (emit_k_reg == 2'd3) && fin_reg;
                        emit_k_next   = emit_k_reg + 1'b1;
                        if (emit_k_reg == 2'd3)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            need_sched_reg <= 1'b1;
            gpos_reg       <= '0;
            ia_reg         <= '0;
            ib_reg         <= '0;
            out_valid_reg  <= 1'b0;
            emit_k_reg     <= '0;
            emit_mark_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            need_sched_reg <= need_sched_next;
            gpos_reg       <= gpos_next;
            ia_reg         <= ia_next;
            ib_reg         <= ib_next;
            out_valid_reg  <= out_valid_next;
            emit_k_reg     <= emit_k_next;
            emit_mark_reg  <= emit_mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        j_reg        <= j_next;
        kidx_reg     <= kidx_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        c_reg        <= c_next;
        fin_reg      <= fin_next;
        held0_reg    <= held0_next;
        held1_reg    <= held1_next;
        e_reg        <= e_next;
        out_char_reg <= out_char_next;
        out_cv_reg   <= out_cv_next;
        out_gl_reg   <= out_gl_next;
        out_re_reg   <= out_re_next;
    end

    assign challenge.ready       = (state_reg == ST_IDLE);
    assign response.valid        = out_valid_reg;
    assign response.out_char     = out_char_reg;
    assign response.char_valid   = out_cv_reg;
    assign response.group_last   = out_gl_reg;
    assign response.response_end = out_re_reg;

endmodule

>>> hdl/rc4b64_chk.sv
// ----------------------------------------------------------------------------
// rc4b64_chk
// Port-level checks on the challenge encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rc4b64_chk
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input rc4b64_pkg::byte_t    out_char,
    input logic                 char_valid,
    input logic                 group_last,
    input logic                 response_end
);
    import rc4b64_pkg::*;

    // a stalled response transaction keeps its valid and payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(group_last)
            && $stable(char_valid) && $stable(response_end))
        else $error("response changed while stalled");

    // end marker carries no character and closes the response
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> out_char == 8'h00 && group_last && response_end)
        else $error("malformed end marker");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && response_end |-> group_last)
        else $error("response end without group last");

    // a taken challenge byte leaves the block busy; no byte is taken on back-to-back cycles
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("challenge taken on back-to-back cycles");

endmodule

bind rc4_variant_challenge_base64_core rc4b64_chk u_rc4b64_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (challenge.valid),
    .in_ready     (challenge.ready),
    .out_valid    (response.valid),
    .out_ready    (response.ready),
    .out_char     (response.out_char),
    .char_valid   (response.char_valid),
    .group_last   (response.group_last),
    .response_end (response.response_end)
);
